// File: rtl/core/look_at_view_matrix_assert.svh
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// Implication checked in the same cycle.
`define LAVM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define LAVM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/lavm_pkg.sv
`default_nettype none

package lavm_pkg;

   localparam int FRAME_W    = 64;
   localparam int UNIT_W     = 18;
   localparam int Q16_W      = 32;
   localparam int MAG_W      = 30;
   localparam int ROOT_STEPS = 32;
   localparam int LEN_W      = 31;
   localparam int QUO_W      = 17;
   localparam int NUM_W      = 48;

   localparam logic [1:0] ROW_U = 2'd0;
   localparam logic [1:0] ROW_V = 2'd1;
   localparam logic [1:0] ROW_N = 2'd2;

   typedef logic [2:0][FRAME_W-1:0] vec_type;
   typedef logic [2:0][UNIT_W-1:0]  unit3_type;
   typedef logic [2:0][Q16_W-1:0]   pos3_type;
   typedef unit3_type [2:0]         rows_type;

   typedef struct packed {
      pos3_type  eye;
      pos3_type  up;
      unit3_type nvec;
      unit3_type vvec;
      logic      ok;
   } ctx_type;

endpackage

`default_nettype wire

// File: rtl/core/look_at_view_matrix.sv
// The first row is offered once the camera has passed every pipeline stage;
// the other two rows follow in turn while rsp_ready stays high.
// Throughput is set by the single result port that carries three rows per
// camera; the 187-stage pipeline takes one per cycle only while it advances.
// Reset is synchronous and clears all valid bits; data registers are not reset.
`default_nettype none
`include "look_at_view_matrix_assert.svh"

module look_at_view_matrix import lavm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_up_x,
   input  logic signed [31:0] req_up_y,
   input  logic signed [31:0] req_up_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_row_index,
   output logic signed [17:0] rsp_row_x,
   output logic signed [17:0] rsp_row_y,
   output logic signed [17:0] rsp_row_z,
   output logic signed [31:0] rsp_row_offset,
   output logic               rsp_degenerate,
   output logic               rsp_last_row
);

   logic adv;

   // Front stage: direction vector and context.
   logic    fr_valid_ff;
   vec_type fr_d_ff;
   ctx_type fr_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else if (adv) begin
         fr_valid_ff   <= req_valid;
         fr_d_ff[0]    <= FRAME_W'(req_target_x) - FRAME_W'(req_eye_x);
         fr_d_ff[1]    <= FRAME_W'(req_target_y) - FRAME_W'(req_eye_y);
         fr_d_ff[2]    <= FRAME_W'(req_target_z) - FRAME_W'(req_eye_z);
         fr_ctx_ff.eye <= {req_eye_z, req_eye_y, req_eye_x};
         fr_ctx_ff.up  <= {req_up_z, req_up_y, req_up_x};
         fr_ctx_ff.nvec <= '0;
         fr_ctx_ff.vvec <= '0;
         fr_ctx_ff.ok   <= 1'b1;
      end
   end

   logic      n1_valid, pj_valid, n2_valid, cr_valid, n3_valid, of_valid;
   unit3_type n1_q, n2_q, n3_q;
   logic      n1_nz, n2_nz, n3_nz;
   ctx_type   n1_ctx, pj_ctx, n2_ctx, cr_ctx, n3_ctx;
   vec_type   pj_vec, cr_vec;
   rows_type  of_rows;
   pos3_type  of_off;
   logic      of_ok;

   lavm_norm u_norm_n (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(fr_valid_ff), .in_vec(fr_d_ff), .in_ctx(fr_ctx_ff),
      .out_valid(n1_valid), .out_q(n1_q), .out_nz(n1_nz), .out_ctx(n1_ctx)
   );

   lavm_proj u_proj (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(n1_valid), .in_q(n1_q), .in_nz(n1_nz), .in_ctx(n1_ctx),
      .out_valid(pj_valid), .out_vec(pj_vec), .out_ctx(pj_ctx)
   );

   lavm_norm u_norm_v (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(pj_valid), .in_vec(pj_vec), .in_ctx(pj_ctx),
      .out_valid(n2_valid), .out_q(n2_q), .out_nz(n2_nz), .out_ctx(n2_ctx)
   );

   lavm_cross u_cross (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(n2_valid), .in_q(n2_q), .in_nz(n2_nz), .in_ctx(n2_ctx),
      .out_valid(cr_valid), .out_vec(cr_vec), .out_ctx(cr_ctx)
   );

   lavm_norm u_norm_u (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(cr_valid), .in_vec(cr_vec), .in_ctx(cr_ctx),
      .out_valid(n3_valid), .out_q(n3_q), .out_nz(n3_nz), .out_ctx(n3_ctx)
   );

   lavm_offs u_offs (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(n3_valid), .in_q(n3_q), .in_nz(n3_nz), .in_ctx(n3_ctx),
      .out_valid(of_valid), .out_rows(of_rows), .out_off(of_off), .out_ok(of_ok)
   );

   // Output stage: holds one camera and sends its rows one per transfer.
   // The whole pipeline moves whenever this stage is empty or its last row
   // goes out.
   logic       out_valid_ff;
   logic [1:0] row_ff;
   rows_type   out_rows_ff;
   pos3_type   out_off_ff;
   logic       out_ok_ff;

   assign adv = !out_valid_ff || (rsp_ready && row_ff == ROW_N);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         row_ff       <= ROW_U;
      end else if (adv) begin
         out_valid_ff <= of_valid;
         row_ff       <= ROW_U;
         out_rows_ff  <= of_rows;
         out_off_ff   <= of_off;
         out_ok_ff    <= of_ok;
      end else if (rsp_ready) begin
         row_ff <= row_ff + 2'd1;
      end
   end

   unit3_type sel_row;
   logic [31:0] sel_off;

   always_comb begin
      case (row_ff)
         ROW_U: begin
            sel_row = out_rows_ff[ROW_U];
            sel_off = out_off_ff[ROW_U];
         end
         ROW_V: begin
            sel_row = out_rows_ff[ROW_V];
            sel_off = out_off_ff[ROW_V];
         end
         default: begin
            sel_row = out_rows_ff[ROW_N];
            sel_off = out_off_ff[ROW_N];
         end
      endcase
   end

   assign req_ready      = adv;
   assign rsp_valid      = out_valid_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_row_x      = out_ok_ff ? sel_row[0] : '0;
   assign rsp_row_y      = out_ok_ff ? sel_row[1] : '0;
   assign rsp_row_z      = out_ok_ff ? sel_row[2] : '0;
   assign rsp_row_offset = out_ok_ff ? sel_off : '0;
   assign rsp_degenerate = !out_ok_ff;
   assign rsp_last_row   = (row_ff == ROW_N);

   `LAVM_ASSERT_NOW(a_degen_zero, rsp_valid && rsp_degenerate, rsp_row_x == '0 && rsp_row_y == '0 && rsp_row_z == '0 && rsp_row_offset == '0, "degenerate row carries data")
   `LAVM_ASSERT_NEXT(a_row_order, rsp_valid && rsp_ready && rsp_row_index != ROW_N, rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1, "rows out of order")
   `LAVM_ASSERT_NOW(a_hold_input, rsp_valid && rsp_row_index != ROW_N, !req_ready, "input taken while rows pending")

endmodule

`default_nettype wire

// File: rtl/core/lavm_norm.sv
`default_nettype none

module lavm_norm import lavm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  vec_type   in_vec,
   input  ctx_type   in_ctx,
   output logic      out_valid,
   output unit3_type out_q,
   output logic      out_nz,
   output ctx_type   out_ctx
);

   typedef struct packed {
      logic [2:0] neg;
      logic       nz;
      ctx_type    ctx;
   } tag_type;

   // Index 3 holds the largest magnitude, 2..0 the components.
   typedef logic [3:0][FRAME_W-1:0] quad_type;

   function automatic quad_type shl_step(input quad_type w, input int k);
      quad_type r;
      r = w;
      if ((w[3] >> (FRAME_W - k)) == '0) begin
         for (int j = 0; j < 4; j++) r[j] = w[j] << k;
      end
      return r;
   endfunction

   // Magnitudes and signs.
   logic               a_valid_ff;
   logic [FRAME_W-1:0] a_mag_ff [3];
   tag_type            a_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         for (int i = 0; i < 3; i++) begin
            a_mag_ff[i]     <= in_vec[i][FRAME_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
            a_tag_ff.neg[i] <= in_vec[i][FRAME_W-1];
         end
         a_tag_ff.nz  <= 1'b0;
         a_tag_ff.ctx <= in_ctx;
      end
   end

   // Largest magnitude.
   logic               b_valid_ff;
   quad_type           b_w_ff;
   tag_type            b_tag_ff;
   logic [FRAME_W-1:0] mx_in;
   tag_type            b_tag_in;

   always_comb begin
      mx_in = a_mag_ff[0];
      if (a_mag_ff[1] > mx_in) mx_in = a_mag_ff[1];
      if (a_mag_ff[2] > mx_in) mx_in = a_mag_ff[2];
      b_tag_in    = a_tag_ff;
      b_tag_in.nz = (mx_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
         b_w_ff     <= {mx_in, a_mag_ff[2], a_mag_ff[1], a_mag_ff[0]};
         b_tag_ff   <= b_tag_in;
      end
   end

   // Left normalization of the whole frame, two shift steps per stage.
   // Since every component is at most the maximum, nothing is lost, and the
   // top bits of the frame equal a truncating right shift of each magnitude.
   logic     sh_valid_ff [3];
   quad_type sh_w_ff     [3];
   tag_type  sh_tag_ff   [3];

   for (genvar s = 0; s < 3; s++) begin : g_shift
      quad_type src_w;
      logic     src_v;
      tag_type  src_t;
      if (s == 0) begin : g_first
         assign src_w = b_w_ff;
         assign src_v = b_valid_ff;
         assign src_t = b_tag_ff;
      end else begin : g_next
         assign src_w = sh_w_ff[s-1];
         assign src_v = sh_valid_ff[s-1];
         assign src_t = sh_tag_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sh_valid_ff[s] <= 1'b0;
         end else if (en) begin
            sh_valid_ff[s] <= src_v;
            sh_w_ff[s]     <= shl_step(shl_step(src_w, 32 >> (2 * s)), 16 >> (2 * s));
            sh_tag_ff[s]   <= src_t;
         end
      end
   end

   // Squares.
   logic               f_valid_ff;
   logic [MAG_W-1:0]   f_m_ff  [3];
   logic [2*MAG_W-1:0] f_sq_ff [3];
   tag_type            f_tag_ff;
   logic [MAG_W-1:0]   m_in    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) m_in[i] = sh_w_ff[2][i][FRAME_W-1 -: MAG_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= sh_valid_ff[2];
         for (int i = 0; i < 3; i++) begin
            f_m_ff[i]  <= m_in[i];
            f_sq_ff[i] <= m_in[i] * m_in[i];
         end
         f_tag_ff <= sh_tag_ff[2];
      end
   end

   // Integer square root, one result bit per stage; entry 0 is the sum.
   logic               rt_valid_ff [ROOT_STEPS+1];
   logic [FRAME_W-1:0] rt_rem_ff   [ROOT_STEPS+1];
   logic [FRAME_W-1:0] rt_res_ff   [ROOT_STEPS+1];
   logic [MAG_W-1:0]   rt_m_ff     [ROOT_STEPS+1][3];
   tag_type            rt_tag_ff   [ROOT_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_valid_ff[0] <= 1'b0;
      end else if (en) begin
         rt_valid_ff[0] <= f_valid_ff;
         rt_rem_ff[0]   <= FRAME_W'(f_sq_ff[0]) + FRAME_W'(f_sq_ff[1])
                           + FRAME_W'(f_sq_ff[2]);
         rt_res_ff[0]   <= '0;
         for (int i = 0; i < 3; i++) rt_m_ff[0][i] <= f_m_ff[i];
         rt_tag_ff[0]   <= f_tag_ff;
      end
   end

   for (genvar j = 1; j <= ROOT_STEPS; j++) begin : g_root
      localparam logic [FRAME_W-1:0] RBIT = FRAME_W'(1) << (2 * (ROOT_STEPS - j));
      logic [FRAME_W-1:0] trial_in;
      assign trial_in = rt_res_ff[j-1] + RBIT;
      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[j] <= 1'b0;
         end else if (en) begin
            rt_valid_ff[j] <= rt_valid_ff[j-1];
            if (rt_rem_ff[j-1] >= trial_in) begin
               rt_rem_ff[j] <= rt_rem_ff[j-1] - trial_in;
               rt_res_ff[j] <= (rt_res_ff[j-1] >> 1) + RBIT;
            end else begin
               rt_rem_ff[j] <= rt_rem_ff[j-1];
               rt_res_ff[j] <= rt_res_ff[j-1] >> 1;
            end
            for (int i = 0; i < 3; i++) rt_m_ff[j][i] <= rt_m_ff[j-1][i];
            rt_tag_ff[j] <= rt_tag_ff[j-1];
         end
      end
   end

   // Restoring division, one quotient bit per stage; entry 0 sets up the
   // rounded numerators.
   logic             dv_valid_ff [QUO_W+1];
   logic [NUM_W-1:0] dv_rem_ff   [QUO_W+1][3];
   logic [QUO_W-1:0] dv_q_ff     [QUO_W+1][3];
   logic [LEN_W-1:0] dv_len_ff   [QUO_W+1];
   tag_type          dv_tag_ff   [QUO_W+1];
   logic [LEN_W-1:0] len_in;

   assign len_in = rt_res_ff[ROOT_STEPS][LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= rt_valid_ff[ROOT_STEPS];
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= NUM_W'({rt_m_ff[ROOT_STEPS][i], 16'b0})
                               + NUM_W'(len_in >> 1);
            dv_q_ff[0][i]   <= '0;
         end
         dv_len_ff[0] <= len_in;
         dv_tag_ff[0] <= rt_tag_ff[ROOT_STEPS];
      end
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_div
      localparam int QB = QUO_W - j;
      logic [NUM_W-1:0] dsr_in;
      assign dsr_in = NUM_W'(dv_len_ff[j-1]) << QB;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j] <= dv_valid_ff[j-1];
            for (int i = 0; i < 3; i++) begin
               if (dv_rem_ff[j-1][i] >= dsr_in) begin
                  dv_rem_ff[j][i] <= dv_rem_ff[j-1][i] - dsr_in;
                  dv_q_ff[j][i]   <= dv_q_ff[j-1][i] | (QUO_W'(1) << QB);
               end else begin
                  dv_rem_ff[j][i] <= dv_rem_ff[j-1][i];
                  dv_q_ff[j][i]   <= dv_q_ff[j-1][i];
               end
            end
            dv_len_ff[j] <= dv_len_ff[j-1];
            dv_tag_ff[j] <= dv_tag_ff[j-1];
         end
      end
   end

   // Signs back on.
   logic      o_valid_ff;
   unit3_type o_q_ff;
   tag_type   o_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= dv_valid_ff[QUO_W];
         for (int i = 0; i < 3; i++) begin
            o_q_ff[i] <= dv_tag_ff[QUO_W].neg[i] ? (UNIT_W'(0) - {1'b0, dv_q_ff[QUO_W][i]})
                                                 : {1'b0, dv_q_ff[QUO_W][i]};
         end
         o_tag_ff <= dv_tag_ff[QUO_W];
      end
   end

   assign out_valid = o_valid_ff;
   assign out_q     = o_q_ff;
   assign out_nz    = o_tag_ff.nz;
   assign out_ctx   = o_tag_ff.ctx;

endmodule

`default_nettype wire

// File: rtl/core/lavm_proj.sv
`default_nettype none

module lavm_proj import lavm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  unit3_type in_q,
   input  logic      in_nz,
   input  ctx_type   in_ctx,
   output logic      out_valid,
   output vec_type   out_vec,
   output ctx_type   out_ctx
);

   logic               p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff, p5_valid_ff;
   ctx_type            p1_ctx_ff, p2_ctx_ff, p3_ctx_ff, p4_ctx_ff, p5_ctx_ff;
   ctx_type            p1_ctx_in;
   logic signed [49:0] p1_prod_ff [3];
   logic signed [51:0] p2_sum_ff;
   logic signed [51:0] rnd_in;
   logic signed [35:0] p3_dot_ff;
   logic signed [53:0] p4_dn_ff [3];
   logic signed [47:0] p4_uu_ff [3];
   vec_type            p5_vec_ff;

   assign rnd_in = p2_sum_ff + 52'sd32768;

   always_comb begin
      p1_ctx_in      = in_ctx;
      p1_ctx_in.nvec = in_q;
      p1_ctx_in.ok   = in_ctx.ok & in_nz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
         for (int i = 0; i < 3; i++) begin
            p1_prod_ff[i] <= $signed(in_ctx.up[i]) * $signed(in_q[i]);
         end
         p1_ctx_ff <= p1_ctx_in;

         p2_valid_ff <= p1_valid_ff;
         p2_sum_ff   <= p1_prod_ff[0] + p1_prod_ff[1] + p1_prod_ff[2];
         p2_ctx_ff   <= p1_ctx_ff;

         // Round half up to Q16.16.
         p3_valid_ff <= p2_valid_ff;
         p3_dot_ff   <= rnd_in[51:16];
         p3_ctx_ff   <= p2_ctx_ff;

         p4_valid_ff <= p3_valid_ff;
         for (int i = 0; i < 3; i++) begin
            p4_dn_ff[i] <= p3_dot_ff * $signed(p3_ctx_ff.nvec[i]);
            p4_uu_ff[i] <= {p3_ctx_ff.up[i], 16'b0};
         end
         p4_ctx_ff <= p3_ctx_ff;

         p5_valid_ff <= p4_valid_ff;
         for (int i = 0; i < 3; i++) p5_vec_ff[i] <= p4_uu_ff[i] - p4_dn_ff[i];
         p5_ctx_ff <= p4_ctx_ff;
      end
   end

   assign out_valid = p5_valid_ff;
   assign out_vec   = p5_vec_ff;
   assign out_ctx   = p5_ctx_ff;

endmodule

`default_nettype wire

// File: rtl/core/lavm_cross.sv
`default_nettype none

module lavm_cross import lavm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  unit3_type in_q,
   input  logic      in_nz,
   input  ctx_type   in_ctx,
   output logic      out_valid,
   output vec_type   out_vec,
   output ctx_type   out_ctx
);

   logic               c1_valid_ff, c2_valid_ff;
   ctx_type            c1_ctx_ff, c2_ctx_ff;
   ctx_type            c1_ctx_in;
   logic signed [35:0] c1_p_ff [6];
   vec_type            c2_vec_ff;

   always_comb begin
      c1_ctx_in      = in_ctx;
      c1_ctx_in.vvec = in_q;
      c1_ctx_in.ok   = in_ctx.ok & in_nz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
      end else if (en) begin
         c1_valid_ff <= in_valid;
         c1_p_ff[0]  <= $signed(in_ctx.nvec[1]) * $signed(in_q[2]);
         c1_p_ff[1]  <= $signed(in_ctx.nvec[2]) * $signed(in_q[1]);
         c1_p_ff[2]  <= $signed(in_ctx.nvec[2]) * $signed(in_q[0]);
         c1_p_ff[3]  <= $signed(in_ctx.nvec[0]) * $signed(in_q[2]);
         c1_p_ff[4]  <= $signed(in_ctx.nvec[0]) * $signed(in_q[1]);
         c1_p_ff[5]  <= $signed(in_ctx.nvec[1]) * $signed(in_q[0]);
         c1_ctx_ff   <= c1_ctx_in;

         c2_valid_ff  <= c1_valid_ff;
         c2_vec_ff[0] <= c1_p_ff[0] - c1_p_ff[1];
         c2_vec_ff[1] <= c1_p_ff[2] - c1_p_ff[3];
         c2_vec_ff[2] <= c1_p_ff[4] - c1_p_ff[5];
         c2_ctx_ff    <= c1_ctx_ff;
      end
   end

   assign out_valid = c2_valid_ff;
   assign out_vec   = c2_vec_ff;
   assign out_ctx   = c2_ctx_ff;

endmodule

`default_nettype wire

// File: rtl/core/lavm_offs.sv
`default_nettype none

module lavm_offs import lavm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  unit3_type in_q,
   input  logic      in_nz,
   input  ctx_type   in_ctx,
   output logic      out_valid,
   output rows_type  out_rows,
   output pos3_type  out_off,
   output logic      out_ok
);

   rows_type           row_in;
   logic               o1_valid_ff, o2_valid_ff, o3_valid_ff, o4_valid_ff;
   rows_type           o1_rows_ff, o2_rows_ff, o3_rows_ff, o4_rows_ff;
   logic               o1_ok_ff, o2_ok_ff, o3_ok_ff, o4_ok_ff;
   logic signed [49:0] o1_p_ff  [3][3];
   logic signed [51:0] o2_s_ff  [3];
   logic signed [51:0] rnd_in   [3];
   logic signed [35:0] o3_r_ff  [3];
   logic signed [36:0] neg_in   [3];
   pos3_type           o4_off_ff;

   assign row_in[ROW_U] = in_q;
   assign row_in[ROW_V] = in_ctx.vvec;
   assign row_in[ROW_N] = in_ctx.nvec;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rnd_in[k] = o2_s_ff[k] + 52'sd32768;
         neg_in[k] = 37'sd0 - o3_r_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o1_valid_ff <= 1'b0;
         o2_valid_ff <= 1'b0;
         o3_valid_ff <= 1'b0;
         o4_valid_ff <= 1'b0;
      end else if (en) begin
         o1_valid_ff <= in_valid;
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               o1_p_ff[k][i] <= $signed(in_ctx.eye[i]) * $signed(row_in[k][i]);
            end
         end
         o1_rows_ff <= row_in;
         o1_ok_ff   <= in_ctx.ok & in_nz;

         o2_valid_ff <= o1_valid_ff;
         for (int k = 0; k < 3; k++) o2_s_ff[k] <= o1_p_ff[k][0] + o1_p_ff[k][1] + o1_p_ff[k][2];
         o2_rows_ff <= o1_rows_ff;
         o2_ok_ff   <= o1_ok_ff;

         o3_valid_ff <= o2_valid_ff;
         for (int k = 0; k < 3; k++) o3_r_ff[k] <= rnd_in[k][51:16];
         o3_rows_ff <= o2_rows_ff;
         o3_ok_ff   <= o2_ok_ff;

         // Negate and clamp to the 32-bit range.
         o4_valid_ff <= o3_valid_ff;
         for (int k = 0; k < 3; k++) begin
            if (neg_in[k] > 37'sd2147483647) begin
               o4_off_ff[k] <= 32'h7FFF_FFFF;
            end else if (neg_in[k] < -37'sd2147483648) begin
               o4_off_ff[k] <= 32'h8000_0000;
            end else begin
               o4_off_ff[k] <= neg_in[k][31:0];
            end
         end
         o4_rows_ff <= o3_rows_ff;
         o4_ok_ff   <= o3_ok_ff;
      end
   end

   assign out_valid = o4_valid_ff;
   assign out_rows  = o4_rows_ff;
   assign out_off   = o4_off_ff;
   assign out_ok    = o4_ok_ff;

endmodule

`default_nettype wire
